>>> rtl/core/pse_pkg.sv
`default_nettype none

package pse_pkg;

    // shortest run that is reported
    localparam int MIN_LEN    = 4;
    // characters held back before a run is known to be long enough
    localparam int HOLD_DEPTH = MIN_LEN - 1;
    // most results one request can cause: burst plus closing newline
    localparam int RES_DEPTH  = MIN_LEN + 1;

    localparam int RL_W  = $clog2(MIN_LEN + 1);
    localparam int CNT_W = $clog2(RES_DEPTH + 1);
    localparam int IDX_W = $clog2(RES_DEPTH);

    typedef logic [7:0]      t_byte;
    typedef logic [6:0]      t_char7;
    typedef logic [RL_W-1:0] t_run_len;
    typedef logic [CNT_W-1:0] t_res_cnt;

    localparam t_byte CH_LOW     = 8'd32;
    localparam t_byte CH_HIGH    = 8'd126;
    localparam t_byte CH_NEWLINE = 8'd10;
    localparam t_byte CH_ZERO    = 8'd0;

endpackage

`default_nettype wire

>>> rtl/core/pse_in_if.sv
`default_nettype none

interface pse_in_if
    import pse_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte in_byte;
    logic  in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pse_out_if.sv
`default_nettype none

interface pse_out_if
    import pse_pkg::*;
();
    logic  valid;
    logic  ready;
    t_byte out_char;
    logic  out_run_last;

    modport source (output valid, output out_char, output out_run_last, input ready);
    modport sink   (input valid, input out_char, input out_run_last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/printable_string_extractor.sv
`default_nettype none

// printable string extractor
// i_in carries one data byte per request plus a last flag marking the end of
// the data. o_out carries the extracted text one character per request:
// run characters, each run closed by a newline, and out_run_last set on the
// final result caused by a given input request.
// runs of printable ascii shorter than MIN_LEN give no output; the first
// MIN_LEN-1 characters are held back and released as one burst once the run
// is long enough, later characters stream through one for one.
// an accepted input passes the input register, then the result register,
// before its first result is offered on o_out.
// throughput: one input per cycle while each input yields at most one
// result and o_out is ready; an input that yields several results (at most
// MIN_LEN+1) holds the result register while o_out drains it one per cycle.
// inputs with no result still pass the result stage and do not hold it.
// when the receiver stalls, the pending results hold and one more input is
// still taken into the input register; i_in.ready then drops.
// reset (synchronous, active low) empties both registers and clears the run
// length and the pending-zero flag; held characters need no reset.

module printable_string_extractor
    import pse_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    pse_in_if.sink    i_in,
    pse_out_if.source o_out
);

    // input register
    logic     r_in_vld;
    t_byte    r_in_byte;
    logic     r_in_last;

    // scan state
    t_run_len r_rl;
    logic     r_pz;
    t_char7   r_held [HOLD_DEPTH];

    // result register, drained from entry 0
    t_byte    r_res [RES_DEPTH];
    t_res_cnt r_cnt;

    // next values
    t_run_len n_rl;
    logic     n_pz;
    t_byte    n_res [RES_DEPTH];
    t_res_cnt n_cnt;
    logic     hold_wr;

    logic     in_fire;
    logic     out_fire;
    logic     move;
    logic     printable;

    assign out_fire  = o_out.valid && o_out.ready;
    assign in_fire   = i_in.valid && i_in.ready;
    // result stage frees up when empty or when its last character leaves
    assign move      = r_in_vld &&
                       ((r_cnt == '0) || (out_fire && (r_cnt == t_res_cnt'(1))));
    assign i_in.ready = !r_in_vld || move;

    assign o_out.valid        = (r_cnt != '0);
    assign o_out.out_char     = r_res[0];
    assign o_out.out_run_last = (r_cnt == t_res_cnt'(1));

    assign printable = (r_in_byte >= CH_LOW) && (r_in_byte <= CH_HIGH);

    // one pass over the registered byte
    always_comb begin
        logic add;
        add     = 1'b0;
        n_rl    = r_rl;
        n_pz    = r_pz;
        n_cnt   = '0;
        hold_wr = 1'b0;
        for (int k = 0; k < RES_DEPTH; k++) begin
            n_res[k] = CH_NEWLINE;
        end

        if (r_pz) begin
            // zero before: printable byte joins the run, anything else ends it
            n_pz = 1'b0;
            if (printable) begin
                add = 1'b1;
            end else begin
                if (r_rl == t_run_len'(MIN_LEN)) begin
                    n_res[0] = CH_NEWLINE;
                    n_cnt    = t_res_cnt'(1);
                end
                n_rl = '0;
                n_pz = (r_in_byte == CH_ZERO);
            end
        end else if (printable) begin
            add = 1'b1;
        end else if (r_in_byte == CH_ZERO) begin
            n_pz = 1'b1;
        end else begin
            if (r_rl == t_run_len'(MIN_LEN)) begin
                n_res[0] = CH_NEWLINE;
                n_cnt    = t_res_cnt'(1);
            end
            n_rl = '0;
        end

        if (add) begin
            if (r_rl < t_run_len'(HOLD_DEPTH)) begin
                hold_wr = 1'b1;
                n_rl    = r_rl + t_run_len'(1);
            end else if (r_rl == t_run_len'(HOLD_DEPTH)) begin
                // run reaches minimum: release held characters plus this one
                for (int k = 0; k < HOLD_DEPTH; k++) begin
                    n_res[k] = {1'b0, r_held[k]};
                end
                n_res[HOLD_DEPTH] = r_in_byte;
                n_cnt             = t_res_cnt'(MIN_LEN);
                n_rl              = t_run_len'(MIN_LEN);
            end else begin
                n_res[0] = r_in_byte;
                n_cnt    = t_res_cnt'(1);
            end
        end

        // end of data flushes the run
        if (r_in_last) begin
            n_pz = 1'b0;
            if (n_rl == t_run_len'(MIN_LEN)) begin
                n_res[n_cnt[IDX_W-1:0]] = CH_NEWLINE;
                n_cnt                   = n_cnt + t_res_cnt'(1);
            end
            n_rl = '0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_fire) begin
            r_in_vld <= 1'b1;
        end else if (move) begin
            r_in_vld <= 1'b0;
        end
        if (in_fire) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rl <= '0;
            r_pz <= 1'b0;
        end else if (move) begin
            r_rl <= n_rl;
            r_pz <= n_pz;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < HOLD_DEPTH; k++) begin
            if (move && hold_wr && (r_rl == t_run_len'(k))) begin
                r_held[k] <= r_in_byte[6:0];
            end
        end
    end

    // result register: load on move, shift on each accepted character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (move) begin
            r_cnt <= n_cnt;
        end else if (out_fire) begin
            r_cnt <= r_cnt - t_res_cnt'(1);
        end
        if (move) begin
            r_res <= n_res;
        end else if (out_fire) begin
            for (int k = 0; k < RES_DEPTH - 1; k++) begin
                r_res[k] <= r_res[k+1];
            end
        end
    end

`ifndef ASSERT_OFF
    a_rl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rl <= t_run_len'(MIN_LEN))
        else $error("run length beyond minimum");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_res_cnt'(RES_DEPTH))
        else $error("result count overflow");

    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in_last) |=> (r_rl == '0) && !r_pz)
        else $error("state not cleared after last byte");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(r_cnt) && $stable(r_res[0]))
        else $error("pending result changed during stall");

    a_no_move_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > t_res_cnt'(1)) |-> !move)
        else $error("result register overwritten");
`endif

endmodule

`default_nettype wire
